// ===== rtl/lane_waypoint_follower_macros.svh =====
// ----------------------------------------------------------------------------
// lane_waypoint_follower_macros.svh
// Assertion macros shared by the lane waypoint follower RTL.
// ----------------------------------------------------------------------------
`ifndef LANE_WAYPOINT_FOLLOWER_MACROS_SVH
`define LANE_WAYPOINT_FOLLOWER_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside of reset.
`define LWF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge outside of reset.
`define LWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants of the lane waypoint follower.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int MAX_POINTS_DEF  = 256;
    localparam int COORD_WIDTH_DEF = 24;

    // Shared multiplier: operands cover a coordinate difference magnitude.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int DIST_W = 64;

    // Direction normalization.
    localparam int MAG_BITS = 20;
    localparam int SUMSQ_W  = 2 * MAG_BITS + 2;
    localparam int V2_W     = 2 * MAG_BITS;
    localparam int FRAC_W   = 15;
    localparam int DIR_W    = 16;
    localparam logic [FRAC_W-1:0] UNIT_ONE = 15'd16384;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam int LEN_W      = 9;
    localparam int RADIUS_W   = 20;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL    = 1'b1;
    localparam logic [RADIUS_W-1:0]  ARRIVAL_RESET  = 20'd2621;

    // Request kinds.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_BEGIN    = 2'd1;
    localparam logic [1:0] REQ_REANCHOR = 2'd2;
    localparam logic [1:0] REQ_STEP     = 2'd3;

    // Travel modes.
    localparam logic [1:0] MODE_INVALID  = 2'd0;
    localparam logic [1:0] MODE_FORWARD  = 2'd1;
    localparam logic [1:0] MODE_BACKWARD = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_op;

endpackage

// ===== rtl/lwf_ram.sv =====
// ----------------------------------------------------------------------------
// lwf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lwf_mul.sv =====
// ----------------------------------------------------------------------------
// lwf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lwf_mul import lwf_pkg::*; (
    input  logic              i_clk,
    input  t_mul_op           i_op,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/lane_waypoint_follower.sv =====
// ----------------------------------------------------------------------------
// lane_waypoint_follower
// Follows one lane of 3-D waypoints: stores points, searches the nearest,
// advances along the lane and emits a unit direction.
// ----------------------------------------------------------------------------
// Usage: an item is taken when i_start is high and o_busy is low. i_req_type
// selects write, begin, reanchor or step. Each item gives exactly one result,
// shown for one cycle with o_done high; the receiver cannot stall it.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
// Sequencing: all arithmetic goes through one shared multiplier and the point
// store has one read port, so the sequencer runs one operation per cycle.
// A begin computes two squared distances per lane point, 3 products each. A
// step computes one distance, shifts the magnitudes down, then runs a binary
// search per axis. o_busy stays high until the result is shown.
// Reset clears the aim index to zero, the mode to invalid, the lane length
// to zero and the arrival radius to its default; the point store is not
// cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`include "lane_waypoint_follower_macros.svh"

module lane_waypoint_follower import lwf_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_req_type,
    input  logic [7:0]                    i_point_index,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    output logic                          o_done,
    output logic signed [DIR_W-1:0]       o_dir_x,
    output logic signed [DIR_W-1:0]       o_dir_y,
    output logic signed [DIR_W-1:0]       o_dir_z,
    output logic [7:0]                    o_current_index,
    output logic [1:0]                    o_travel_mode
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = AW + 1;
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 3 * CW;
    localparam int XW = AW + 10;
    localparam int FW = 73;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_DIST = 4'd3;
    localparam logic [3:0] S_DOT  = 4'd4;
    localparam logic [3:0] S_DM   = 4'd5;
    localparam logic [3:0] S_SH   = 4'd6;
    localparam logic [3:0] S_SQ   = 4'd7;
    localparam logic [3:0] S_V2   = 4'd8;
    localparam logic [3:0] S_V2W  = 4'd9;
    localparam logic [3:0] S_BS   = 4'd10;
    localparam logic [3:0] S_T2   = 4'd11;
    localparam logic [3:0] S_M1   = 4'd12;
    localparam logic [3:0] S_M2   = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    localparam logic [2:0] PH_BEGIN = 3'd0;
    localparam logic [2:0] PH_ANCH  = 3'd1;
    localparam logic [2:0] PH_STEP  = 3'd2;
    localparam logic [2:0] PH_PC    = 3'd3;
    localparam logic [2:0] PH_PNX   = 3'd4;
    localparam logic [2:0] PH_STEP2 = 3'd5;

    function automatic logic [CW-1:0] coord(input logic [PW-1:0] v, input logic [1:0] k);
        unique case (k)
            2'd0:    return v[0 +: CW];
            2'd1:    return v[CW +: CW];
            2'd2:    return v[2*CW +: CW];
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [DW-1:0] sdiff(input logic [CW-1:0] a,
                                                   input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic [DW-1:0] magof(input logic signed [DW-1:0] d);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // Control registers.
    logic [3:0]          r_state, n_state;
    logic                r_done, n_done;
    logic [AW-1:0]       r_aim, n_aim;
    logic [1:0]          r_mode, n_mode;
    logic [LEN_W-1:0]    r_lane_len;
    logic [RADIUS_W-1:0] r_arrival;

    // Working registers.
    logic [2:0]          r_ph, n_ph;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_tgt, n_tgt;
    logic [NW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_addr, n_addr;
    logic [1:0]          r_k, n_k;
    logic                r_q, n_q;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_W-1:0]    r_ps, n_ps;
    logic [ACC_W-1:0]    r_ng, n_ng;
    logic                r_xs, n_xs;
    logic [AW-1:0]       r_best_c, n_best_c;
    logic [AW-1:0]       r_best_t, n_best_t;
    logic [DIST_W-1:0]   r_bd_c, n_bd_c;
    logic [DIST_W-1:0]   r_bd_t, n_bd_t;
    logic [PW-1:0]       r_pc, n_pc;
    logic [AW-1:0]       r_nx, n_nx;
    logic [DW-1:0]       r_m [3];
    logic [DW-1:0]       n_m [3];
    logic [2:0]          r_neg, n_neg;
    logic [DW-1:0]       r_mx, n_mx;
    logic [SUMSQ_W-1:0]  r_s, n_s;
    logic [V2_W-1:0]     r_v2, n_v2;
    logic [1:0]          r_ck, n_ck;
    logic [FRAC_W-1:0]   r_lo, n_lo;
    logic [FRAC_W-1:0]   r_hi, n_hi;
    logic [FRAC_W-1:0]   r_mid, n_mid;
    logic [29:0]         r_t2, n_t2;
    logic [50:0]         r_plo, n_plo;
    logic [DIR_W-1:0]    r_dir [3];
    logic [DIR_W-1:0]    n_dir [3];

    // Datapath wires.
    t_mul_op             w_op;
    logic [PROD_W-1:0]   w_prod;
    logic [PW-1:0]       w_rdata;
    logic                w_accept;
    logic                w_wr_en;
    logic [AW+7:0]       w_pidx_ext;
    logic [XW-1:0]       w_len_ext;
    logic [NW-1:0]       w_len;
    logic                w_fwd;
    logic                w_travel;
    logic [AW-1:0]       w_last;
    logic [AW-1:0]       w_nlast;
    logic [1:0]          w_kk;
    logic [ACC_W-1:0]    w_sum;
    logic [DIST_W-1:0]   w_dist;
    logic [PW-1:0]       w_query;
    logic [AW:0]         w_aim_inc;
    logic [AW-1:0]       w_adv;
    logic                w_upd;
    logic [AW-1:0]       w_cbest;
    logic [AW-1:0]       w_tbest;
    logic [ACC_W-1:0]    w_ps_add;
    logic [ACC_W-1:0]    w_ng_add;
    logic signed [DW-1:0] w_da;
    logic signed [DW-1:0] w_db;
    logic signed [DW-1:0] w_dd [3];
    logic [DW-1:0]       w_dm [3];
    logic [DW-1:0]       w_mx01;
    logic [FRAC_W:0]     w_mid_sum;
    logic [FRAC_W-1:0]   w_mid;
    logic [FRAC_W-1:0]   w_t;
    logic [FW-1:0]       w_full;
    logic [FW-1:0]       w_rhs;
    logic [AW+7:0]       w_aim_ext;

    lwf_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_wr_en),
        .i_waddr(w_pidx_ext[AW-1:0]),
        .i_wdata({i_pos_z, i_pos_y, i_pos_x}),
        .i_re   (r_state == S_RD),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    lwf_mul u_mul (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_prod(w_prod)
    );

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_pidx_ext = (AW + 8)'(i_point_index);
    assign w_wr_en    = w_accept && (i_req_type == REQ_WRITE)
                        && (w_pidx_ext < (AW + 8)'(MAX_POINTS));

    assign w_len_ext = XW'(r_lane_len);
    assign w_len     = NW'((w_len_ext < XW'(MAX_POINTS)) ? w_len_ext : XW'(MAX_POINTS));

    assign w_fwd    = (r_mode == MODE_FORWARD);
    assign w_travel = (r_mode == MODE_FORWARD) || (r_mode == MODE_BACKWARD);
    assign w_nlast  = AW'(r_n - 1'b1);
    assign w_last   = w_fwd ? w_nlast : '0;
    assign w_kk     = (r_k == 2'd3) ? 2'd0 : r_k;

    assign w_sum  = r_acc + ACC_W'(w_prod);
    assign w_dist = (|w_sum[ACC_W-1:DIST_W]) ? '1 : w_sum[DIST_W-1:0];
    assign w_query = r_q ? r_tgt : r_pos;

    assign w_aim_inc = {1'b0, r_aim} + 1'b1;
    assign w_adv = w_fwd ? ((w_aim_inc >= (AW + 1)'(MAX_POINTS)) ? '0 : w_aim_inc[AW-1:0])
                         : r_aim - 1'b1;

    assign w_ps_add = r_ps + (r_xs ? '0 : ACC_W'(w_prod));
    assign w_ng_add = r_ng + (r_xs ? ACC_W'(w_prod) : '0);

    assign w_da = sdiff(coord(w_rdata, w_kk), coord(r_pc, w_kk));
    assign w_db = sdiff(coord(r_pc, w_kk), coord(r_pos, w_kk));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dd[k] = sdiff(coord(w_rdata, 2'(k)), coord(r_pos, 2'(k)));
            w_dm[k] = magof(w_dd[k]);
        end
    end
    assign w_mx01 = (w_dm[0] > w_dm[1]) ? w_dm[0] : w_dm[1];

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign w_mid     = w_mid_sum[FRAC_W:1];
    assign w_t       = FRAC_W'({w_mid, 1'b0} - 1'b1);

    assign w_full = {1'b0, w_prod[50:0], 21'b0} + FW'(r_plo);
    assign w_rhs  = {3'b0, r_v2, 30'b0};

    // First-minimum update of the running best point.
    assign w_upd   = (r_i == '0) || (w_dist < r_bd_c);
    assign w_cbest = w_upd ? r_i : r_best_c;
    assign w_tbest = ((r_i == '0) || (w_dist < r_bd_t)) ? r_i : r_best_t;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_aim    = r_aim;
        n_mode   = r_mode;
        n_ph     = r_ph;
        n_pos    = r_pos;
        n_tgt    = r_tgt;
        n_n      = r_n;
        n_i      = r_i;
        n_addr   = r_addr;
        n_k      = r_k;
        n_q      = r_q;
        n_acc    = r_acc;
        n_ps     = r_ps;
        n_ng     = r_ng;
        n_xs     = r_xs;
        n_best_c = r_best_c;
        n_best_t = r_best_t;
        n_bd_c   = r_bd_c;
        n_bd_t   = r_bd_t;
        n_pc     = r_pc;
        n_nx     = r_nx;
        n_m      = r_m;
        n_neg    = r_neg;
        n_mx     = r_mx;
        n_s      = r_s;
        n_v2     = r_v2;
        n_ck     = r_ck;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_t2     = r_t2;
        n_plo    = r_plo;
        n_dir    = r_dir;
        w_op     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos = {i_pos_z, i_pos_y, i_pos_x};
                    n_tgt = {i_target_z, i_target_y, i_target_x};
                    n_n   = w_len;
                    n_i   = '0;
                    n_dir = '{default: '0};
                    n_state = S_DONE;
                    unique case (i_req_type)
                        REQ_WRITE: begin
                        end
                        REQ_BEGIN: begin
                            if (w_len == '0) begin
                                n_aim  = '0;
                                n_mode = MODE_INVALID;
                            end else begin
                                n_addr  = '0;
                                n_ph    = PH_BEGIN;
                                n_state = S_RD;
                            end
                        end
                        REQ_REANCHOR: begin
                            if (w_travel && (w_len >= NW'(2))) begin
                                n_addr  = '0;
                                n_ph    = PH_ANCH;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            if (w_travel && (w_len != '0)) begin
                                n_addr  = r_aim;
                                n_ph    = PH_STEP;
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_LD;
            end

            S_LD: begin
                n_k = '0;
                n_q = 1'b0;
                unique case (r_ph)
                    PH_BEGIN, PH_ANCH, PH_STEP: n_state = S_DIST;
                    PH_PC: begin
                        n_pc    = w_rdata;
                        n_addr  = r_nx;
                        n_ph    = PH_PNX;
                        n_state = S_RD;
                    end
                    PH_PNX:   n_state = S_DOT;
                    PH_STEP2: n_state = S_DM;
                    default:  n_state = S_DONE;
                endcase
            end

            // Squared distance: one axis product issued per cycle.
            S_DIST: begin
                w_op.a = MUL_W'(magof(sdiff(coord(w_rdata, w_kk), coord(w_query, w_kk))));
                w_op.b = w_op.a;
                n_k    = r_k + 1'b1;
                n_acc  = (r_k == 2'd0) ? '0 : w_sum;
                if (r_k == 2'd3) begin
                    unique case (r_ph)
                        PH_BEGIN: begin
                            if (!r_q) begin
                                n_best_c = w_cbest;
                                if (w_upd) begin
                                    n_bd_c = w_dist;
                                end
                                n_q = 1'b1;
                                n_k = '0;
                            end else begin
                                n_best_t = w_tbest;
                                if (w_tbest == r_i) begin
                                    n_bd_t = w_dist;
                                end
                                if (r_i == w_nlast) begin
                                    n_aim   = r_best_c;
                                    n_mode  = (r_best_c < w_tbest) ? MODE_FORWARD
                                                                   : MODE_BACKWARD;
                                    n_state = S_DONE;
                                end else begin
                                    n_i     = r_i + 1'b1;
                                    n_addr  = r_i + 1'b1;
                                    n_state = S_RD;
                                end
                            end
                        end
                        PH_ANCH: begin
                            n_best_c = w_cbest;
                            if (w_upd) begin
                                n_bd_c = w_dist;
                            end
                            if (r_i == w_nlast) begin
                                if (w_cbest == w_last) begin
                                    n_aim   = w_cbest;
                                    n_state = S_DONE;
                                end else begin
                                    n_nx    = w_fwd ? w_cbest + 1'b1 : w_cbest - 1'b1;
                                    n_addr  = w_cbest;
                                    n_ph    = PH_PC;
                                    n_state = S_RD;
                                end
                            end else begin
                                n_i     = r_i + 1'b1;
                                n_addr  = r_i + 1'b1;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            if (w_dist < DIST_W'(r_arrival)) begin
                                if (r_aim == w_last) begin
                                    n_mode  = MODE_FINISHED;
                                    n_state = S_DONE;
                                end else begin
                                    n_aim   = w_adv;
                                    n_addr  = w_adv;
                                    n_ph    = PH_STEP2;
                                    n_state = S_RD;
                                end
                            end else begin
                                n_state = S_DM;
                            end
                        end
                    endcase
                end
            end

            // Segment test: products of the segment and offset magnitudes,
            // summed by sign into positive and negative parts.
            S_DOT: begin
                w_op.a = MUL_W'(magof(w_da));
                w_op.b = MUL_W'(magof(w_db));
                n_xs   = w_da[DW-1] ^ w_db[DW-1];
                n_k    = r_k + 1'b1;
                if (r_k == 2'd0) begin
                    n_ps = '0;
                    n_ng = '0;
                end else begin
                    n_ps = w_ps_add;
                    n_ng = w_ng_add;
                end
                if (r_k == 2'd3) begin
                    n_aim   = (w_ng_add <= w_ps_add) ? r_best_c : r_nx;
                    n_state = S_DONE;
                end
            end

            S_DM: begin
                n_m     = w_dm;
                n_neg   = {w_dd[2][DW-1], w_dd[1][DW-1], w_dd[0][DW-1]};
                n_mx    = (w_mx01 > w_dm[2]) ? w_mx01 : w_dm[2];
                n_state = S_SH;
            end

            // Scale all axes together until the largest fits the square unit.
            S_SH: begin
                if ((r_mx >> MAG_BITS) != '0) begin
                    n_mx = r_mx >> 1;
                    for (int k = 0; k < 3; k++) begin
                        n_m[k] = r_m[k] >> 1;
                    end
                end else begin
                    n_k     = '0;
                    n_state = S_SQ;
                end
            end

            S_SQ: begin
                w_op.a = MUL_W'(r_m[w_kk]);
                w_op.b = w_op.a;
                n_k    = r_k + 1'b1;
                n_acc  = (r_k == 2'd0) ? '0 : w_sum;
                if (r_k == 2'd3) begin
                    n_s     = SUMSQ_W'(w_sum);
                    n_ck    = '0;
                    n_state = S_V2;
                end
            end

            S_V2: begin
                w_op.a  = MUL_W'(r_m[r_ck]);
                w_op.b  = w_op.a;
                n_state = S_V2W;
            end

            S_V2W: begin
                n_v2    = w_prod[V2_W-1:0];
                n_lo    = '0;
                n_hi    = UNIT_ONE;
                n_state = S_BS;
            end

            // Largest q with (2q-1)^2 * s <= v^2 * 2^30 gives the rounded
            // component of v * 16384 / sqrt(s).
            S_BS: begin
                if ((r_s != '0) && (r_lo < r_hi)) begin
                    w_op.a  = MUL_W'(w_t);
                    w_op.b  = w_op.a;
                    n_mid   = w_mid;
                    n_state = S_T2;
                end else begin
                    if (r_s == '0) begin
                        n_dir[r_ck] = '0;
                    end else begin
                        n_dir[r_ck] = r_neg[r_ck] ? DIR_W'(0) - DIR_W'(r_lo) : DIR_W'(r_lo);
                    end
                    if (r_ck == 2'd2) begin
                        n_state = S_DONE;
                    end else begin
                        n_ck    = r_ck + 1'b1;
                        n_state = S_V2;
                    end
                end
            end

            S_T2: begin
                n_t2    = w_prod[29:0];
                w_op.a  = MUL_W'(w_prod[29:0]);
                w_op.b  = MUL_W'(r_s[20:0]);
                n_state = S_M1;
            end

            S_M1: begin
                n_plo   = w_prod[50:0];
                w_op.a  = MUL_W'(r_t2);
                w_op.b  = MUL_W'(r_s[SUMSQ_W-1:21]);
                n_state = S_M2;
            end

            S_M2: begin
                if (w_full <= w_rhs) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid - 1'b1;
                end
                n_state = S_BS;
            end

            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_aim      <= '0;
            r_mode     <= MODE_INVALID;
            r_lane_len <= '0;
            r_arrival  <= ARRIVAL_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_aim   <= n_aim;
            r_mode  <= n_mode;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_LANE_LENGTH: r_lane_len <= i_cfg_data[LEN_W-1:0];
                    REG_ARRIVAL:     r_arrival  <= i_cfg_data[RADIUS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph     <= n_ph;
        r_pos    <= n_pos;
        r_tgt    <= n_tgt;
        r_n      <= n_n;
        r_i      <= n_i;
        r_addr   <= n_addr;
        r_k      <= n_k;
        r_q      <= n_q;
        r_acc    <= n_acc;
        r_ps     <= n_ps;
        r_ng     <= n_ng;
        r_xs     <= n_xs;
        r_best_c <= n_best_c;
        r_best_t <= n_best_t;
        r_bd_c   <= n_bd_c;
        r_bd_t   <= n_bd_t;
        r_pc     <= n_pc;
        r_nx     <= n_nx;
        r_m      <= n_m;
        r_neg    <= n_neg;
        r_mx     <= n_mx;
        r_s      <= n_s;
        r_v2     <= n_v2;
        r_ck     <= n_ck;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_t2     <= n_t2;
        r_plo    <= n_plo;
        r_dir    <= n_dir;
    end

    assign w_aim_ext       = (AW + 8)'(r_aim);
    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_dir_x         = r_dir[0];
    assign o_dir_y         = r_dir[1];
    assign o_dir_z         = r_dir[2];
    assign o_current_index = w_aim_ext[7:0];
    assign o_travel_mode   = r_mode;

    `LWF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, o_busy, "accepted item did not raise busy")
    `LWF_ASSERT_IMPLIES(a_done_idle, i_clk, i_rst_n, o_done, !o_busy && $past(o_busy), "result strobe outside end of item")
    `LWF_ASSERT_IMPLIES(a_fin_zero, i_clk, i_rst_n, o_done && (o_travel_mode == MODE_FINISHED), (o_dir_x == '0) && (o_dir_y == '0) && (o_dir_z == '0), "finished lane gave a direction")

endmodule

// ===== verif/tb_lane_waypoint_follower.sv =====
// ----------------------------------------------------------------------------
// tb_lane_waypoint_follower
// Self-checking bench for the lane waypoint follower. A table of directed
// items runs first, then the point store is filled, then random lane phases
// with begin/step/reanchor sequences built around the stored geometry. Results
// are checked against an in-bench predictor or, for typed rows, fixed values.
// ----------------------------------------------------------------------------
module tb_lane_waypoint_follower;
    import lwf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS        = 256;
    localparam int CW          = 24;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 700;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] slot;
        vec3_t      pos;
        vec3_t      tgt;
    } lane_item_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic [7:0]              aim;
        logic [1:0]              mode;
    } steer_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        lane_item_t            item;
        logic                  has_exp;
        steer_t                exp;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_req_type;
    logic [7:0]            i_point_index;
    coord_t                i_pos_x, i_pos_y, i_pos_z;
    coord_t                i_target_x, i_target_y, i_target_z;
    logic                  o_done;
    logic signed [DIR_W-1:0] o_dir_x, o_dir_y, o_dir_z;
    logic [7:0]            o_current_index;
    logic [1:0]            o_travel_mode;

    lane_waypoint_follower u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_point_index(i_point_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .o_done(o_done), .o_dir_x(o_dir_x), .o_dir_y(o_dir_y), .o_dir_z(o_dir_z),
        .o_current_index(o_current_index), .o_travel_mode(o_travel_mode)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state.
    vec3_t       wp_mirror [NPTS];
    logic [7:0]  aim_mirror;
    logic [1:0]  mode_mirror;
    logic [8:0]  len_mirror;
    logic [19:0] radius_mirror;

    steer_t   steer_q[$];
    dir_row_t rows[$];
    int       errors = 0;
    int       items_sent = 0;
    int       cycles = 0;

    function automatic logic [63:0] coord_mag(longint d);
        return d < 0 ? 64'(-d) : 64'(d);
    endfunction

    function automatic logic [63:0] sq_dist(vec3_t p, vec3_t q);
        logic [63:0] s, m, sq;
        s = 0;
        m = coord_mag(longint'(p.x) - longint'(q.x));
        sq = m * m;
        s = (s > ~sq) ? '1 : s + sq;
        m = coord_mag(longint'(p.y) - longint'(q.y));
        sq = m * m;
        s = (s > ~sq) ? '1 : s + sq;
        m = coord_mag(longint'(p.z) - longint'(q.z));
        sq = m * m;
        s = (s > ~sq) ? '1 : s + sq;
        return s;
    endfunction

    function automatic int closest_point(vec3_t q, int n);
        int best;
        logic [63:0] bd, d;
        best = 0;
        bd = sq_dist(wp_mirror[0], q);
        for (int i = 1; i < n; i++) begin
            d = sq_dist(wp_mirror[i], q);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic logic signed [DIR_W-1:0] unit_comp(logic [63:0] m, logic neg,
                                                          logic [63:0] s);
        logic [63:0]  lo, hi, mid, t;
        logic [127:0] rhs, lhs;
        lo = 0;
        hi = 16384;
        rhs = {64'd0, m * m} << 30;
        if (s == 0) return '0;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return neg ? -DIR_W'(lo) : DIR_W'(lo);
    endfunction

    function automatic void heading(vec3_t to, vec3_t from, output steer_t r);
        longint d [3];
        logic [63:0] m [3];
        logic [63:0] mx, s;
        d[0] = longint'(to.x) - longint'(from.x);
        d[1] = longint'(to.y) - longint'(from.y);
        d[2] = longint'(to.z) - longint'(from.z);
        mx = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = coord_mag(d[k]);
            if (m[k] > mx) mx = m[k];
        end
        // Common shift keeps every magnitude below 2^20 before squaring.
        while (mx >= 64'(1 << MAG_BITS)) begin
            mx = mx >> 1;
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
        end
        for (int k = 0; k < 3; k++) s += m[k] * m[k];
        r.dx = unit_comp(m[0], d[0] < 0, s);
        r.dy = unit_comp(m[1], d[1] < 0, s);
        r.dz = unit_comp(m[2], d[2] < 0, s);
    endfunction

    function automatic steer_t follow_item(lane_item_t it);
        steer_t r;
        int n, c, t, last, nx;
        logic fwd, finished;
        logic [127:0] ps, ng, p;
        longint a, b;
        r = '0;
        n = (len_mirror < NPTS) ? int'(len_mirror) : NPTS;
        case (it.req)
            REQ_WRITE: wp_mirror[it.slot] = it.pos;
            REQ_BEGIN: begin
                if (n == 0) begin
                    aim_mirror = 0;
                    mode_mirror = MODE_INVALID;
                end else begin
                    c = closest_point(it.pos, n);
                    t = closest_point(it.tgt, n);
                    aim_mirror = 8'(c);
                    mode_mirror = (c < t) ? MODE_FORWARD : MODE_BACKWARD;
                end
            end
            REQ_REANCHOR: begin
                if ((mode_mirror == MODE_FORWARD || mode_mirror == MODE_BACKWARD) &&
                    n >= 2) begin
                    fwd = (mode_mirror == MODE_FORWARD);
                    c = closest_point(it.pos, n);
                    last = fwd ? n - 1 : 0;
                    if (c == last) begin
                        aim_mirror = 8'(c);
                    end else begin
                        nx = fwd ? c + 1 : c - 1;
                        ps = 0;
                        ng = 0;
                        // Sign of the dot product of the onward segment with
                        // the vector from the position to the nearest point.
                        for (int k = 0; k < 3; k++) begin
                            case (k)
                                0: begin
                                    a = longint'(wp_mirror[nx].x) - longint'(wp_mirror[c].x);
                                    b = longint'(wp_mirror[c].x) - longint'(it.pos.x);
                                end
                                1: begin
                                    a = longint'(wp_mirror[nx].y) - longint'(wp_mirror[c].y);
                                    b = longint'(wp_mirror[c].y) - longint'(it.pos.y);
                                end
                                default: begin
                                    a = longint'(wp_mirror[nx].z) - longint'(wp_mirror[c].z);
                                    b = longint'(wp_mirror[c].z) - longint'(it.pos.z);
                                end
                            endcase
                            p = 128'(coord_mag(a) * coord_mag(b));
                            if ((a < 0) != (b < 0)) ng += p;
                            else ps += p;
                        end
                        aim_mirror = (ng <= ps) ? 8'(c) : 8'(nx);
                    end
                end
            end
            default: begin
                if ((mode_mirror == MODE_FORWARD || mode_mirror == MODE_BACKWARD) &&
                    n > 0) begin
                    fwd = (mode_mirror == MODE_FORWARD);
                    last = fwd ? n - 1 : 0;
                    finished = 1'b0;
                    if (sq_dist(it.pos, wp_mirror[aim_mirror]) < 64'(radius_mirror)) begin
                        if (int'(aim_mirror) == last) begin
                            mode_mirror = MODE_FINISHED;
                            finished = 1'b1;
                        end else if (fwd) begin
                            aim_mirror = aim_mirror + 8'd1;
                        end else begin
                            aim_mirror = aim_mirror - 8'd1;
                        end
                    end
                    if (!finished) heading(wp_mirror[aim_mirror], it.pos, r);
                end
            end
        endcase
        r.aim = aim_mirror;
        r.mode = mode_mirror;
        return r;
    endfunction

    // Result checking: one result per accepted item, in order.
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        steer_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("lane_waypoint_follower regression: fail");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (steer_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual idx %0d mode %0d",
                         $time, o_current_index, o_travel_mode);
                errors++;
            end else begin
                e = steer_q.pop_front();
                check_field("dir_x", e.dx, o_dir_x);
                check_field("dir_y", e.dy, o_dir_y);
                check_field("dir_z", e.dz, o_dir_z);
                check_field("current_index", e.aim, o_current_index);
                check_field("travel_mode", e.mode, o_travel_mode);
            end
        end
    end

    // Drives one item and waits until it is taken. A zero gap keeps start
    // high from the previous item so it is never dropped and raised at once.
    task automatic send_item(lane_item_t it, logic use_typed, steer_t typed);
        int gap;
        steer_t pred;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_req_type    <= it.req;
        i_point_index <= it.slot;
        i_pos_x       <= it.pos.x;
        i_pos_y       <= it.pos.y;
        i_pos_z       <= it.pos.z;
        i_target_x    <= it.tgt.x;
        i_target_y    <= it.tgt.y;
        i_target_z    <= it.tgt.z;
        do @(posedge i_clk); while (o_busy);
        pred = follow_item(it);
        steer_q.push_back(use_typed ? typed : pred);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (steer_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_LANE_LENGTH) len_mirror = data[LEN_W-1:0];
        else radius_mirror = data[RADIUS_W-1:0];
    endtask

    function automatic vec3_t mk_vec(coord_t x, coord_t y, coord_t z);
        vec3_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic vec3_t rand_vec();
        return mk_vec(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endfunction

    function automatic vec3_t jitter(vec3_t p, int amp);
        vec3_t v;
        v.x = p.x + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
        v.y = p.y + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
        v.z = p.z + coord_t'(int'($urandom_range(0, 2 * amp)) - amp);
        return v;
    endfunction

    function automatic lane_item_t mk_item(logic [1:0] req, logic [7:0] slot,
                                           vec3_t pos, vec3_t tgt);
        lane_item_t it;
        it.req = req;
        it.slot = slot;
        it.pos = pos;
        it.tgt = tgt;
        return it;
    endfunction

    function automatic steer_t mk_exp(logic [7:0] aim, logic [1:0] mode);
        steer_t e;
        e = '0;
        e.aim = aim;
        e.mode = mode;
        return e;
    endfunction

    task automatic add_item(lane_item_t it);
        dir_row_t r;
        r = '0;
        r.item = it;
        rows.push_back(r);
    endtask

    task automatic add_typed(lane_item_t it, steer_t e);
        dir_row_t r;
        r = '0;
        r.item = it;
        r.has_exp = 1'b1;
        r.exp = e;
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        rows.push_back(r);
    endtask

    // Lays out a lane as a jittered straight line so that steps can arrive.
    task automatic build_lane(int n);
        vec3_t base, stride;
        base = mk_vec(coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22)),
                      coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22)),
                      coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22)));
        stride = mk_vec(coord_t'(int'($urandom_range(0, 8192)) - 4096),
                        coord_t'(int'($urandom_range(0, 8192)) - 4096),
                        coord_t'(int'($urandom_range(0, 8192)) - 4096));
        for (int i = 0; i < n; i++) begin
            send_item(mk_item(REQ_WRITE, 8'(i), jitter(base, 64), '0), 1'b0, '0);
            base.x = base.x + stride.x;
            base.y = base.y + stride.y;
            base.z = base.z + stride.z;
        end
    endtask

    localparam coord_t CMAX = coord_t'(24'h7FFFFF);
    localparam coord_t CMIN = coord_t'(24'h800000);

    initial begin
        int n, steps, full_phases, pick;
        vec3_t vmax, vmin;
        lane_item_t it;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_start       <= 1'b0;
        i_req_type    <= REQ_WRITE;
        i_point_index <= '0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_pos_z       <= '0;
        i_target_x    <= '0;
        i_target_y    <= '0;
        i_target_z    <= '0;
        aim_mirror    = 0;
        mode_mirror   = MODE_INVALID;
        len_mirror    = 0;
        radius_mirror = ARRIVAL_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        vmax = mk_vec(CMAX, CMAX, CMAX);
        vmin = mk_vec(CMIN, CMIN, CMIN);

        // Directed: nothing travels after reset, then a two-point lane at the
        // coordinate extremes, lengths one and two, and radius extremes.
        add_typed(mk_item(REQ_STEP, 8'd0, vmax, vmin), mk_exp(8'd0, MODE_INVALID));
        add_typed(mk_item(REQ_REANCHOR, 8'd0, vmin, vmax), mk_exp(8'd0, MODE_INVALID));
        add_typed(mk_item(REQ_BEGIN, 8'd0, vmax, vmin), mk_exp(8'd0, MODE_INVALID));
        add_item(mk_item(REQ_WRITE, 8'd0, vmax, '0));
        add_item(mk_item(REQ_WRITE, 8'd1, vmin, '0));
        add_cfg(REG_LANE_LENGTH, 20'd1);
        add_typed(mk_item(REQ_BEGIN, 8'd0, vmax, vmin), mk_exp(8'd0, MODE_BACKWARD));
        add_item(mk_item(REQ_REANCHOR, 8'd0, vmin, '0));
        add_item(mk_item(REQ_STEP, 8'd0, vmin, '0));
        add_cfg(REG_LANE_LENGTH, 20'd2);
        add_typed(mk_item(REQ_BEGIN, 8'd0, vmax, vmin), mk_exp(8'd0, MODE_FORWARD));
        add_item(mk_item(REQ_STEP, 8'd0, vmin, '0));
        add_item(mk_item(REQ_STEP, 8'd0, vmax, '0));
        add_item(mk_item(REQ_REANCHOR, 8'd0, vmin, '0));
        add_item(mk_item(REQ_STEP, 8'd0, vmin, '0));
        add_item(mk_item(REQ_STEP, 8'd0, vmin, '0));
        add_cfg(REG_ARRIVAL, 20'd0);
        add_typed(mk_item(REQ_BEGIN, 8'd0, vmin, vmax), mk_exp(8'd1, MODE_BACKWARD));
        add_item(mk_item(REQ_STEP, 8'd0, vmin, '0));
        add_cfg(REG_ARRIVAL, 20'hFFFFF);
        add_item(mk_item(REQ_REANCHOR, 8'd0, vmax, '0));
        add_item(mk_item(REQ_STEP, 8'd0, vmax, '0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) cfg_write(rows[i].cfg_idx, rows[i].cfg_data);
            else send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
        end

        // Fill every slot so that no later read touches an unwritten point.
        for (int i = 0; i < NPTS; i++)
            send_item(mk_item(REQ_WRITE, 8'(i), rand_vec(), rand_vec()), 1'b0, '0);

        // Longest lane setting with all length bits set, over a random store.
        cfg_write(REG_LANE_LENGTH, 20'd511);
        send_item(mk_item(REQ_BEGIN, 8'd0, rand_vec(), rand_vec()), 1'b0, '0);
        send_item(mk_item(REQ_REANCHOR, 8'd0, rand_vec(), rand_vec()), 1'b0, '0);
        send_item(mk_item(REQ_STEP, 8'd0, rand_vec(), rand_vec()), 1'b0, '0);

        full_phases = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) n = $urandom_range(0, 1);
            else if (pick == 1 && full_phases < 2) begin
                n = NPTS;
                full_phases++;
            end else n = $urandom_range(2, 16);
            cfg_write(REG_LANE_LENGTH, 20'(n));
            cfg_write(REG_ARRIVAL, ($urandom_range(0, 4) == 0) ?
                      20'($urandom) : 20'($urandom_range(4096, 20'hFFFFF)));
            if (n > 0 && n < NPTS && $urandom_range(0, 2) != 0) build_lane(n);
            if (n == 0) n = 1;
            send_item(mk_item(REQ_BEGIN, 8'($urandom),
                              jitter(wp_mirror[$urandom_range(0, n - 1)], 32),
                              jitter(wp_mirror[$urandom_range(0, n - 1)], 32)), 1'b0, '0);
            steps = (n == NPTS) ? 6 : $urandom_range(8, 30);
            for (int s = 0; s < steps; s++) begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    it = mk_item(REQ_STEP, 8'($urandom),
                                 jitter(wp_mirror[aim_mirror], (pick < 10) ? 16 : 4096),
                                 rand_vec());
                else if (pick < 16)
                    it = mk_item(REQ_REANCHOR, 8'($urandom),
                                 jitter(wp_mirror[$urandom_range(0, n - 1)], 2048),
                                 rand_vec());
                else if (pick == 16)
                    it = mk_item(REQ_BEGIN, 8'($urandom),
                                 jitter(wp_mirror[$urandom_range(0, n - 1)], 32),
                                 jitter(wp_mirror[$urandom_range(0, n - 1)], 32));
                else if (pick == 17)
                    it = mk_item(REQ_WRITE, 8'($urandom_range(0, n - 1)),
                                 jitter(wp_mirror[$urandom_range(0, n - 1)], 512),
                                 rand_vec());
                else
                    it = mk_item(2'($urandom), 8'($urandom), rand_vec(), rand_vec());
                send_item(it, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("lane_waypoint_follower regression: pass");
        end else begin
            $display("lane_waypoint_follower regression: fail");
        end
        $finish;
    end

endmodule
